FILE: sv/pap_pkg.sv
// Shared constants and types for the pulse amplitude / pileup block.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none
package pap_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int PREGATE       = 25;
    localparam int LAG           = 6;
    localparam int TRACE_LEN_MAX = 256;
    localparam int WIN           = 2 * LAG;

    localparam int CNT_W   = $clog2(TRACE_LEN_MAX + 2);
    localparam int POS_W   = 8;
    localparam int DEPTH_W = 16;
    localparam int SEP_W   = 8;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 2;
    localparam int AMP_W   = 25;

    localparam logic [IDX_W-1:0] REG_DIP_DEPTH  = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_PULSE_SEP  = IDX_W'(1);
    // unused indexes, writes to them are ignored
    localparam logic [IDX_W-1:0] REG_SPARE_2    = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_SPARE_3    = IDX_W'(3);
    localparam logic [DEPTH_W-1:0] DIP_DEPTH_RST = DEPTH_W'(50);
    localparam logic [SEP_W-1:0]   PULSE_SEP_RST = SEP_W'(30);

    localparam int SUM_W = SAMPLE_W + $clog2(PREGATE + 1);
    localparam int NUM_W = SUM_W + 1;

    // amplitude = floor((num*512 + PREGATE) / (2*PREGATE)), done as a
    // reciprocal multiply that is exact for every x below 2^X_W
    localparam int X_W    = 25 + $clog2(PREGATE);
    localparam int DIV    = 2 * PREGATE;
    localparam int REC_SH = X_W + $clog2(DIV);
    localparam int REC_W  = X_W + 1;
    localparam int PROD_W = X_W + REC_W;
    localparam int Q_W    = PROD_W - REC_SH;
    localparam logic [REC_W-1:0] REC =
        REC_W'(((64'd1 << REC_SH) + 64'(DIV) - 64'd1) / 64'(DIV));
    localparam logic [AMP_W-1:0] AMP_MAX = {1'b0, {(AMP_W-1){1'b1}}};

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};

    // end-of-trace snapshot handed to the amplitude pipeline
    typedef struct packed {
        logic signed [SUM_W-1:0]    sum;
        logic signed [SAMPLE_W-1:0] min;
        logic [POS_W-1:0]           idx;
        logic                       pileup;
        logic                       err;
    } fin_t;

endpackage
`default_nettype wire

FILE: sv/pap_cell.sv
// One tap of the sample window: holds a sample, hands it on when shifted.
// Depends on pap_pkg.
`default_nettype none
module pap_cell (
    input  wire logic                                 clk,
    input  wire logic                                 shift,
    input  wire logic signed [pap_pkg::SAMPLE_W-1:0]  din,
    output logic signed [pap_pkg::SAMPLE_W-1:0]       dout
);

    logic signed [pap_pkg::SAMPLE_W-1:0] tap_reg;

    // window is only read after being written in the same trace: no reset
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            tap_reg <= din;
        end
    end

    assign dout = tap_reg;

endmodule
`default_nettype wire

FILE: sv/pap_amp.sv
// Elastic amplitude pipeline: baseline minus scaled minimum, then a
// reciprocal multiply for the rounded mean. Depends on pap_pkg.
`default_nettype none
module pap_amp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                fin_valid,
    output logic                                     fin_ready,
    input  wire pap_pkg::fin_t                       fin,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [pap_pkg::AMP_W-1:0]         amplitude,
    output logic [pap_pkg::POS_W-1:0]                peak_index,
    output logic                                     pileup,
    output logic                                     length_error
);

    pap_pkg::fin_t s1_reg;
    logic          s1_v_reg;

    logic [pap_pkg::X_W-1:0]   s2_x_reg;
    logic [pap_pkg::POS_W-1:0] s2_idx_reg;
    logic                      s2_pu_reg;
    logic                      s2_err_reg;
    logic                      s2_v_reg;

    logic [pap_pkg::PROD_W-1:0] s3_prod_reg;
    logic [pap_pkg::POS_W-1:0]  s3_idx_reg;
    logic                       s3_pu_reg;
    logic                       s3_err_reg;
    logic                       s3_v_reg;

    logic signed [pap_pkg::AMP_W-1:0] amp_reg;
    logic [pap_pkg::POS_W-1:0]        idx_reg;
    logic                             pu_reg;
    logic                             err_reg;
    logic                             ov_reg;

    logic o_rdy, s3_rdy, s2_rdy, s1_rdy;
    logic signed [pap_pkg::NUM_W-1:0] num;
    logic [pap_pkg::X_W-1:0]          x_next;
    logic [pap_pkg::Q_W-1:0]          q;
    logic [pap_pkg::AMP_W-1:0]        amp_next;

    assign o_rdy  = !ov_reg || !out_stall;
    assign s3_rdy = !s3_v_reg || o_rdy;
    assign s2_rdy = !s2_v_reg || s3_rdy;
    assign s1_rdy = !s1_v_reg || s2_rdy;
    assign fin_ready = s1_rdy;

    always_comb
    begin
        num = pap_pkg::NUM_W'(s1_reg.sum)
            - pap_pkg::NUM_W'(s1_reg.min) * pap_pkg::NUM_W'(pap_pkg::PREGATE);
        if (num < 0)
        begin
            x_next = '0;
        end
        else
        begin
            x_next = (pap_pkg::X_W'($unsigned(num)) << 9) + pap_pkg::X_W'(pap_pkg::PREGATE);
        end
    end

    always_comb
    begin
        q = s3_prod_reg[pap_pkg::PROD_W-1:pap_pkg::REC_SH];
        if (s3_err_reg)
        begin
            amp_next = '0;
        end
        else if (q[pap_pkg::Q_W-1])
        begin
            amp_next = pap_pkg::AMP_MAX;
        end
        else
        begin
            amp_next = pap_pkg::AMP_W'(q);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
            s3_v_reg <= 1'b0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            if (s1_rdy)
            begin
                s1_v_reg <= fin_valid;
            end
            if (s2_rdy)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (s3_rdy)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (o_rdy)
            begin
                ov_reg <= s3_v_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_rdy && fin_valid)
        begin
            s1_reg <= fin;
        end
        if (s2_rdy && s1_v_reg)
        begin
            s2_x_reg   <= x_next;
            s2_idx_reg <= s1_reg.idx;
            s2_pu_reg  <= s1_reg.pileup;
            s2_err_reg <= s1_reg.err;
        end
        if (s3_rdy && s2_v_reg)
        begin
            s3_prod_reg <= pap_pkg::PROD_W'(s2_x_reg) * pap_pkg::PROD_W'(pap_pkg::REC);
            s3_idx_reg  <= s2_idx_reg;
            s3_pu_reg   <= s2_pu_reg;
            s3_err_reg  <= s2_err_reg;
        end
        if (o_rdy && s3_v_reg)
        begin
            amp_reg <= $signed(amp_next);
            idx_reg <= s3_err_reg ? '0 : s3_idx_reg;
            pu_reg  <= s3_pu_reg && !s3_err_reg;
            err_reg <= s3_err_reg;
        end
    end

    assign out_valid    = ov_reg;
    assign amplitude    = amp_reg;
    assign peak_index   = idx_reg;
    assign pileup       = pu_reg;
    assign length_error = err_reg;

endmodule
`default_nettype wire

FILE: sv/pulse_amplitude_pileup.sv
// Pulse height analysis with pileup detection: trace tracking, the
// sample window cell chain and the amplitude pipeline. Depends on pap_pkg.
//
// Usage: one signed sample per input beat on in_valid/in_stall, with last
// marking the final sample of a trace. Only the last beat of a trace makes
// an output beat (amplitude, peak_index, pileup, length_error) on
// out_valid/out_stall; other beats produce nothing.
// Throughput: one sample per cycle while in_stall is low. The sample window
// is a chain of 2*LAG cells shifting once per accepted beat within
// TRACE_LEN_MAX samples; the baseline, minimum and dip compares settle in
// that same cycle. The last beat's snapshot is registered in the first slot,
// then the subtract, reciprocal multiply and output registers follow in order.
// A new trace may start in the cycle after a last beat.
// Stall: while out_stall holds, results collect in the four pipeline slots;
// once all four are full in_stall rises for any input beat until the
// receiver takes a result; nothing is dropped.
// Reset: control state clears, dip_depth returns to 50 and
// pulse_separation to 30; there is no clearing pass.
// cfg_wr_en writes register cfg_index: 0 dip_depth, 1 pulse_separation.
`default_nettype none
module pulse_amplitude_pileup (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_valid,
    output logic                                     in_stall,
    input  wire logic signed [pap_pkg::SAMPLE_W-1:0] sample,
    input  wire logic                                last,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output logic signed [pap_pkg::AMP_W-1:0]         amplitude,
    output logic [pap_pkg::POS_W-1:0]                peak_index,
    output logic                                     pileup,
    output logic                                     length_error,
    input  wire logic                                cfg_wr_en,
    input  wire logic [pap_pkg::IDX_W-1:0]           cfg_index,
    input  wire logic [pap_pkg::CFG_W-1:0]           cfg_data
);

    logic [pap_pkg::DEPTH_W-1:0] dip_depth_reg;
    logic [pap_pkg::SEP_W-1:0]   pulse_sep_reg;

    logic signed [pap_pkg::SUM_W-1:0]    sum_reg, sum_next;
    logic signed [pap_pkg::SAMPLE_W-1:0] min_reg, min_next;
    logic [pap_pkg::POS_W-1:0]           minpos_reg, minpos_next;
    logic [pap_pkg::CNT_W-1:0]           cnt_reg, cnt_next;
    logic [pap_pkg::POS_W-1:0]           lastdip_reg, lastdip_next;
    logic                                dipseen_reg, dipseen_next;
    logic                                pu_reg, pu_next;

    logic                                 accept, active, fin_ready, is_dip;
    logic [pap_pkg::POS_W-1:0]            p;
    logic signed [pap_pkg::SAMPLE_W:0]    d_old, d_new;
    logic signed [pap_pkg::SAMPLE_W-1:0]  tap [pap_pkg::WIN];
    logic signed [pap_pkg::SAMPLE_W-1:0]  oldest, center;
    pap_pkg::fin_t                        fin;

    assign in_stall = !fin_ready;
    assign accept   = in_valid && fin_ready;
    assign active   = cnt_reg < pap_pkg::CNT_W'(pap_pkg::TRACE_LEN_MAX);

    // tap[0] is the newest sample, tap[WIN-1] the one 2*LAG back
    for (genvar i = 0; i < pap_pkg::WIN; i++)
    begin : g_cell
        pap_cell u_cell (
            .clk   (clk),
            .shift (accept && active),
            .din   ((i == 0) ? sample : tap[(i == 0) ? 0 : i - 1]),
            .dout  (tap[i])
        );
    end

    assign oldest = tap[pap_pkg::WIN-1];
    assign center = tap[pap_pkg::LAG-1];
    assign d_old  = (pap_pkg::SAMPLE_W+1)'(oldest) - (pap_pkg::SAMPLE_W+1)'(center);
    assign d_new  = (pap_pkg::SAMPLE_W+1)'(sample) - (pap_pkg::SAMPLE_W+1)'(center);
    assign p      = cnt_reg[pap_pkg::POS_W-1:0] - pap_pkg::POS_W'(pap_pkg::LAG);
    assign is_dip = active && (cnt_reg >= pap_pkg::CNT_W'(pap_pkg::WIN))
                 && ((pap_pkg::SAMPLE_W+2)'(d_old) > $signed({2'b00, dip_depth_reg}))
                 && ((pap_pkg::SAMPLE_W+2)'(d_new) > $signed({2'b00, dip_depth_reg}));

    // per-sample update, before the end-of-trace clear
    always_comb
    begin
        sum_next     = sum_reg;
        min_next     = min_reg;
        minpos_next  = minpos_reg;
        lastdip_next = lastdip_reg;
        dipseen_next = dipseen_reg;
        pu_next      = pu_reg;
        cnt_next     = pap_pkg::CNT_W'(pap_pkg::TRACE_LEN_MAX + 1);
        if (active)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg < pap_pkg::CNT_W'(pap_pkg::PREGATE))
            begin
                sum_next = sum_reg + pap_pkg::SUM_W'(sample);
            end
            if (sample < min_reg)
            begin
                min_next    = sample;
                minpos_next = cnt_reg[pap_pkg::POS_W-1:0];
            end
            if (is_dip)
            begin
                if (dipseen_reg && ((p - lastdip_reg) > pulse_sep_reg))
                begin
                    pu_next = 1'b1;
                end
                lastdip_next = p;
                dipseen_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        fin.sum    = sum_next;
        fin.min    = min_next;
        fin.idx    = minpos_next;
        fin.pileup = pu_next;
        fin.err    = (cnt_next < pap_pkg::CNT_W'(pap_pkg::PREGATE))
                  || (cnt_next > pap_pkg::CNT_W'(pap_pkg::TRACE_LEN_MAX));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dip_depth_reg <= pap_pkg::DIP_DEPTH_RST;
            pulse_sep_reg <= pap_pkg::PULSE_SEP_RST;
            sum_reg       <= '0;
            min_reg       <= pap_pkg::SAMPLE_MAX;
            minpos_reg    <= '0;
            cnt_reg       <= '0;
            lastdip_reg   <= '0;
            dipseen_reg   <= 1'b0;
            pu_reg        <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    pap_pkg::REG_DIP_DEPTH: dip_depth_reg <= cfg_data[pap_pkg::DEPTH_W-1:0];
                    pap_pkg::REG_PULSE_SEP: pulse_sep_reg <= cfg_data[pap_pkg::SEP_W-1:0];
                    default: ;
                endcase
            end
            if (accept)
            begin
                if (last)
                begin
                    sum_reg     <= '0;
                    min_reg     <= pap_pkg::SAMPLE_MAX;
                    minpos_reg  <= '0;
                    cnt_reg     <= '0;
                    lastdip_reg <= '0;
                    dipseen_reg <= 1'b0;
                    pu_reg      <= 1'b0;
                end
                else
                begin
                    sum_reg     <= sum_next;
                    min_reg     <= min_next;
                    minpos_reg  <= minpos_next;
                    cnt_reg     <= cnt_next;
                    lastdip_reg <= lastdip_next;
                    dipseen_reg <= dipseen_next;
                    pu_reg      <= pu_next;
                end
            end
        end
    end

    pap_amp u_amp (
        .clk          (clk),
        .rst_n        (rst_n),
        .fin_valid    (in_valid && last),
        .fin_ready    (fin_ready),
        .fin          (fin),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .amplitude    (amplitude),
        .peak_index   (peak_index),
        .pileup       (pileup),
        .length_error (length_error)
    );

endmodule
`default_nettype wire
